[rtl/core/lots_pkg.sv]
// Shared constants, types and state encodings of the letter order sorter.
package lots_pkg;

    localparam int ALPHA_SIZE   = 26;
    localparam int MAX_WORD_LEN = 64;
    localparam int LETTER_W     = 5;
    localparam int CNT_W        = $clog2(ALPHA_SIZE + 1);
    localparam int POS_W        = $clog2(MAX_WORD_LEN + 1);
    localparam int ADDR_W       = $clog2(MAX_WORD_LEN);
    localparam int BYTE_W       = 8;

    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHA_SIZE - 1);

    typedef enum logic [0:0] {
        IN_IDLE,
        IN_CMP
    } t_in_state;

    typedef enum logic [2:0] {
        G_IDLE,
        G_SEED,
        G_POP,
        G_SCAN,
        G_CHECK,
        G_EMIT
    } t_g_state;

    typedef struct packed {
        logic                set_edge;
        logic [LETTER_W-1:0] edge_from;
        logic [LETTER_W-1:0] edge_to;
        logic                mark;
        logic [LETTER_W-1:0] letter;
        logic                start;
    } t_graph_req;

endpackage

[rtl/core/letter_order_topo_sort_unit.sv]
// Top level of the letter order sorter: word intake and comparison, graph walk.
// Each letter item is handled in two steps: the stored letter of the previous
// word at the current position is read from the 64-entry word memory, then it is
// compared, an edge set and the new letter written back. The item that ends the
// list starts the walk, during which no item is taken: seeding over all 26
// letters, one pop per queued letter until the queue runs dry, a scan of all 26
// rows per used letter, one check, then one result per cycle as the output
// side takes them.
// Intake resumes once the final result sits in the output register.
module letter_order_topo_sort_unit
    import lots_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,  // letter
    input  logic              s_tuser,  // word_end
    input  logic              s_tlast,  // list_end
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,  // out_letter
    output logic              m_tuser,  // order_found
    output logic              m_tlast   // last_of_run
);

    t_in_state r_in_state, n_in_state;

    logic [LETTER_W-1:0] r_prev_word [MAX_WORD_LEN];
    logic [LETTER_W-1:0] r_prev_q, r_ch, ch_in;
    logic                r_wend, r_lend;
    logic [POS_W-1:0]    r_pos, r_prev_len, pos_inc;
    logic                r_diff, r_first;
    logic                graph_busy, in_range, do_cmp, new_edge;
    t_graph_req          req;

    always_comb begin
        n_in_state = r_in_state;
        unique case (r_in_state)
            IN_IDLE: if (s_tvalid && s_tready) n_in_state = IN_CMP;
            IN_CMP:  n_in_state = IN_IDLE;
            default: n_in_state = IN_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (r_in_state == IN_IDLE) && !graph_busy;
        ch_in         = (s_tdata[LETTER_W-1:0] > LAST_LETTER) ? LAST_LETTER
                                                               : s_tdata[LETTER_W-1:0];
        in_range      = (r_pos < POS_W'(MAX_WORD_LEN));
        do_cmp        = in_range && !r_first && !r_diff && (r_pos < r_prev_len);
        new_edge      = do_cmp && (r_prev_q != r_ch);
        pos_inc       = in_range ? r_pos + 1'b1 : r_pos;
        req.mark      = (r_in_state == IN_CMP);
        req.letter    = r_ch;
        req.set_edge  = (r_in_state == IN_CMP) && new_edge;
        req.edge_from = r_prev_q;
        req.edge_to   = r_ch;
        req.start     = (r_in_state == IN_CMP) && r_lend;
    end

    always_ff @(posedge i_clk) begin
        r_prev_q <= r_prev_word[r_pos[ADDR_W-1:0]];
        if (r_in_state == IN_CMP && in_range) begin
            r_prev_word[r_pos[ADDR_W-1:0]] <= r_ch;
        end
        if (s_tvalid && s_tready) begin
            r_ch   <= ch_in;
            r_wend <= s_tuser || s_tlast;
            r_lend <= s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_state <= IN_IDLE;
            r_pos      <= '0;
            r_prev_len <= '0;
            r_diff     <= 1'b0;
            r_first    <= 1'b1;
        end else begin
            r_in_state <= n_in_state;
            if (r_in_state == IN_CMP) begin
                if (new_edge) r_diff <= 1'b1;
                r_pos <= pos_inc;
                if (r_wend) begin
                    r_prev_len <= pos_inc;
                    r_pos      <= '0;
                    r_diff     <= 1'b0;
                    r_first    <= 1'b0;
                end
                if (r_lend) begin
                    r_prev_len <= '0;
                    r_first    <= 1'b1;
                end
            end
        end
    end

    lots_graph u_graph (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .o_busy   (graph_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/core/lots_graph.sv]
// Precedence graph store, Kahn walk sequencer and result output register.
module lots_graph
    import lots_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_graph_req        i_req,
    output logic              o_busy,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,  // out_letter
    output logic              m_tuser,  // order_found
    output logic              m_tlast   // last_of_run
);

    t_g_state r_state, n_state;

    logic [ALPHA_SIZE-1:0] r_edge [ALPHA_SIZE];
    logic [ALPHA_SIZE-1:0] r_used;
    logic [LETTER_W-1:0]   r_queue [ALPHA_SIZE];
    logic [LETTER_W-1:0]   r_order [ALPHA_SIZE];
    logic [CNT_W-1:0]      r_head, r_tail, r_count;
    logic [LETTER_W-1:0]   r_idx, r_nx;
    logic                  r_fail;
    logic                  r_out_valid;
    logic [LETTER_W-1:0]   r_out_letter;
    logic                  r_out_found, r_out_last;

    logic [ALPHA_SIZE-1:0] row_sel, row_clr;
    logic [LETTER_W-1:0]   head_letter;
    logic [CNT_W-1:0]      cnt_dec;
    logic                  queue_empty, push, out_load, emit_last, any_edge, idx_last;

    always_comb begin
        any_edge = 1'b0;
        for (int i = 0; i < ALPHA_SIZE; i++) begin
            any_edge = any_edge | (|r_edge[i]);
        end
    end

    always_comb begin
        row_sel          = r_edge[r_idx];
        row_clr          = row_sel;
        row_clr[r_nx]    = 1'b0;
        head_letter      = r_queue[r_head[LETTER_W-1:0]];
        queue_empty      = (r_head == r_tail);
        idx_last         = (r_idx == LAST_LETTER);
        cnt_dec          = r_count - 1'b1;
        emit_last        = r_fail || (r_count == CNT_W'(1));
        out_load         = (r_state == G_EMIT) && (!r_out_valid || m_tready);
        push             = 1'b0;
        unique case (r_state)
            G_SEED:  push = (row_sel == '0);
            G_SCAN:  push = row_sel[r_nx] && (row_clr == '0);
            default: push = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            G_IDLE:  if (i_req.start) n_state = G_SEED;
            G_SEED:  if (idx_last) n_state = G_POP;
            G_POP: begin
                if (queue_empty) begin
                    n_state = G_CHECK;
                end else if (r_used[head_letter]) begin
                    n_state = G_SCAN;
                end
            end
            G_SCAN:  if (idx_last) n_state = G_POP;
            G_CHECK: n_state = G_EMIT;
            G_EMIT:  if (out_load && emit_last) n_state = G_IDLE;
            default: n_state = G_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= G_IDLE;
            r_edge      <= '{default: '0};
            r_used      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_fail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (push) begin
                r_tail <= r_tail + 1'b1;
            end
            unique case (r_state)
                G_IDLE: begin
                    if (i_req.mark) r_used[i_req.letter] <= 1'b1;
                    if (i_req.set_edge) r_edge[i_req.edge_from][i_req.edge_to] <= 1'b1;
                    r_idx <= '0;
                end
                G_SEED: begin
                    r_idx <= idx_last ? '0 : r_idx + 1'b1;
                end
                G_POP: begin
                    r_idx <= '0;
                    if (!queue_empty) begin
                        r_head <= r_head + 1'b1;
                        if (r_used[head_letter]) r_count <= r_count + 1'b1;
                    end
                end
                G_SCAN: begin
                    if (row_sel[r_nx]) r_edge[r_idx] <= row_clr;
                    r_idx <= idx_last ? '0 : r_idx + 1'b1;
                end
                G_CHECK: begin
                    r_fail <= any_edge || (r_count == '0);
                end
                G_EMIT: begin
                    if (out_load) begin
                        if (emit_last) begin
                            r_edge  <= '{default: '0};
                            r_used  <= '0;
                            r_head  <= '0;
                            r_tail  <= '0;
                            r_count <= '0;
                            r_fail  <= 1'b0;
                        end else begin
                            r_count <= cnt_dec;
                        end
                    end
                end
                default: r_idx <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_tail[LETTER_W-1:0]] <= r_idx;
        end
        if (r_state == G_POP && !queue_empty && r_used[head_letter]) begin
            r_order[r_count[LETTER_W-1:0]] <= head_letter;
            r_nx                           <= head_letter;
        end
        if (out_load) begin
            r_out_letter <= r_fail ? '0 : r_order[cnt_dec[LETTER_W-1:0]];
            r_out_found  <= !r_fail;
            r_out_last   <= emit_last;
        end
    end

    assign o_busy   = (r_state != G_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = BYTE_W'(r_out_letter);
    assign m_tuser  = r_out_found;
    assign m_tlast  = r_out_last;

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= CNT_W'(ALPHA_SIZE))
        else $error("queue tail past alphabet");

    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head past tail");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == G_IDLE) |-> (r_count == '0 && r_tail == '0 && !r_fail))
        else $error("walk state not cleared");

endmodule

[test/tb_order_checker.sv]
// Checker for the letter order sorter: predicts the derived order and compares results.
module tb_order_checker
    import lots_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,  // letter
    input  logic              s_tuser,  // word_end
    input  logic              s_tlast,  // list_end
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [BYTE_W-1:0] m_tdata,  // out_letter
    input  logic              m_tuser,  // order_found
    input  logic              m_tlast,  // last_of_run
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                found;
        logic                last;
    } t_order_item;

    t_order_item         order_q[$];
    logic [LETTER_W-1:0] prev_word[MAX_WORD_LEN];
    int                  prev_len;
    int                  pos;
    bit                  diff_seen;
    bit                  first_word;
    logic [31:0]         edges[ALPHA_SIZE];
    logic [31:0]         used;

    int errors;

    assign o_errors  = errors;
    assign o_pending = order_q.size();

    task automatic clear_graph();
        prev_len   = 0;
        pos        = 0;
        diff_seen  = 0;
        first_word = 1;
        used       = '0;
        for (int i = 0; i < ALPHA_SIZE; i++) edges[i] = '0;
    endtask

    task automatic walk_and_queue();
        int          outdeg[ALPHA_SIZE];
        int          rq[$];
        int          found[$];
        int          nx;
        bit          cyc;
        t_order_item it;
        for (int i = 0; i < ALPHA_SIZE; i++) begin
            outdeg[i] = $countones(edges[i]);
            if (outdeg[i] == 0) rq = {rq, i};
        end
        while (rq.size() > 0) begin
            nx = rq.pop_front();
            if (!used[nx]) continue;
            found = {found, nx};
            for (int i = 0; i < ALPHA_SIZE; i++) begin
                if (edges[i][nx]) begin
                    edges[i][nx] = 1'b0;
                    if (outdeg[i] > 0) outdeg[i]--;
                    if (outdeg[i] == 0) rq = {rq, i};
                end
            end
        end
        cyc = 0;
        for (int i = 0; i < ALPHA_SIZE; i++) if (outdeg[i] != 0) cyc = 1;
        if (cyc || found.size() == 0) begin
            it = '{letter: '0, found: 1'b0, last: 1'b1};
            order_q = {order_q, it};
        end else begin
            for (int k = found.size() - 1; k >= 0; k--) begin
                it = '{letter: LETTER_W'(found[k]), found: 1'b1, last: k == 0};
                order_q = {order_q, it};
            end
        end
    endtask

    task automatic take_letter(input logic [BYTE_W-1:0] raw, input bit w_end, input bit l_end);
        int ch;
        ch = (raw[LETTER_W-1:0] >= ALPHA_SIZE) ? ALPHA_SIZE - 1 : int'(raw[LETTER_W-1:0]);
        used[ch] = 1'b1;
        if (pos < MAX_WORD_LEN) begin
            if (!first_word && !diff_seen && pos < prev_len && prev_word[pos] != ch) begin
                edges[prev_word[pos]][ch] = 1'b1;
                diff_seen = 1;
            end
            prev_word[pos] = LETTER_W'(ch);
            pos++;
        end
        if (w_end || l_end) begin
            prev_len   = pos;
            pos        = 0;
            diff_seen  = 0;
            first_word = 0;
        end
        if (l_end) begin
            walk_and_queue();
            clear_graph();
        end
    endtask

    initial begin
        errors = 0;
        clear_graph();
    end

    always @(posedge i_clk) begin
        t_order_item exp_item;
        if (!i_rst_n) begin
            clear_graph();
        end else begin
            if (s_tvalid && s_tready) take_letter(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                if (order_q.size() == 0) begin
                    $display("%0t: unexpected result letter=%0d found=%0b last=%0b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    exp_item = order_q.pop_front();
                    if (m_tdata !== BYTE_W'(exp_item.letter) || m_tuser !== exp_item.found
                            || m_tlast !== exp_item.last) begin
                        $display({"%0t: mismatch expected letter=%0d found=%0b last=%0b,",
                                  " actual letter=%0d found=%0b last=%0b"},
                                 $time, exp_item.letter, exp_item.found, exp_item.last,
                                 m_tdata, m_tuser, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

[test/tb_top.sv]
// Testbench top for the letter order sorter: stimulus, idling and verdict.
module tb_top;
    import lots_pkg::*;

    localparam int WATCHDOG = 20000;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;  // letter
    logic              s_tuser;  // word_end
    logic              s_tlast;  // list_end
    logic              m_tvalid;
    logic              m_tready;
    logic [BYTE_W-1:0] m_tdata;  // out_letter
    logic              m_tuser;  // order_found
    logic              m_tlast;  // last_of_run
    int                errors;
    int                pending;
    int                idle_cycles;
    int                n_sent;
    bit                calm;
    bit                stim_done;

    letter_order_topo_sort_unit dut (.*);

    tb_order_checker chk (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 0;
    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // receiver stalls in bursts
    initial begin
        int n;
        m_tready = 0;
        forever begin
            @(posedge i_clk);
            if (calm || $urandom_range(0, 2) != 0) begin
                m_tready <= 1;
            end else begin
                n = $urandom_range(1, 16);
                m_tready <= 0;
                repeat (n - 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_letter(input logic [BYTE_W-1:0] l, input bit we, input bit le);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata  <= l;
        s_tuser  <= we;
        s_tlast  <= le;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic send_word(input int len, input int max_l, input bit last_word);
        for (int i = 0; i < len; i++)
            send_letter(BYTE_W'($urandom_range(0, max_l)), i == len - 1,
                        last_word && i == len - 1);
    endtask

    task automatic send_list(input int words, input int max_l);
        for (int w = 0; w < words; w++)
            send_word($urandom_range(1, 4), max_l, w == words - 1);
    endtask

    initial begin
        i_rst_n   = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tuser   = 0;
        s_tlast   = 0;
        calm      = 0;
        stim_done = 0;
        n_sent    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // ordered chain: ab, ac, b -> a<b? edges b->c, a->b
        send_letter(0, 0, 0); send_letter(1, 1, 0);
        send_letter(0, 0, 0); send_letter(2, 1, 0);
        send_letter(1, 1, 1);
        // cycle: a, b, a
        send_letter(0, 1, 0); send_letter(1, 1, 0); send_letter(0, 1, 1);
        // longer word before its prefix, then lone letter z
        send_letter(3, 0, 0); send_letter(4, 1, 0); send_letter(3, 1, 1);
        send_letter(25, 1, 1);
        // out of range letters saturate, plus bit 7
        send_letter(8'd31, 0, 0); send_letter(8'hFF, 1, 0); send_letter(8'd24, 1, 1);
        // list end without word end, last letter 0
        send_letter(5, 0, 0); send_letter(0, 0, 1);
        // one long word beyond the word memory, then a differing word
        for (int i = 0; i < MAX_WORD_LEN + 2; i++)
            send_letter(BYTE_W'(i % ALPHA_SIZE), i == MAX_WORD_LEN + 1, 0);
        send_letter(7, 1, 1);
        // hold off until every result is back
        s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        while (n_sent < 160) begin
            if (n_sent > 120) calm = 1;
            if ($urandom_range(0, 9) == 0) begin
                send_list($urandom_range(1, 5), 31);
            end else begin
                send_list($urandom_range(2, 8), $urandom_range(1, 25));
            end
        end
        s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
